// File: hw/rtl/clf_pkg.sv
`default_nettype none

package clf_pkg;

   localparam int CHAR_W    = 8;
   localparam int TIME_W    = 32;
   localparam int NUM_CHARS = 5;

   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'h0d;
   localparam logic [CHAR_W-1:0] CH_LF        = 8'h0a;
   localparam logic [CHAR_W-1:0] CH_LOWER_A   = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z   = 8'h7a;
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_E         = 8'h45;
   localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
   localparam logic [CHAR_W-1:0] CH_TWO       = 8'h32;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;

   typedef enum logic {
      KIND_LINE  = 1'b0,
      KIND_ERROR = 1'b1
   } frame_kind_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_ms;
      logic [CHAR_W-1:0] rx_byte;
   } rx_item_type;

   typedef struct packed {
      frame_kind_type                     kind;
      logic [TIME_W-1:0]                  frame_time;
      logic [NUM_CHARS-1:0][CHAR_W-1:0]   chars;
   } frame_type;

endpackage

`default_nettype wire

// File: hw/rtl/clf_in_reg.sv
`default_nettype none

module clf_in_reg
   import clf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire rx_item_type in_item,
   output logic             in_ready,
   input  wire logic        take,
   output logic             out_valid,
   output rx_item_type      out_item
);

   logic        valid_ff;
   logic        valid_in;
   rx_item_type item_ff;

   assign in_ready = !reset && (!valid_ff || take);
   assign valid_in = (in_valid && in_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// File: hw/rtl/clf_framer.sv
`default_nettype none

module clf_framer
   import clf_pkg::*;
#(
   parameter int LINE_LENGTH = 5
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [TIME_W-1:0] csr_wdata,
   input  wire logic              item_valid,
   input  wire rx_item_type       item,
   output logic                   item_take,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output frame_type              out_frame
);

   localparam int CNT_W = $clog2(LINE_LENGTH + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(LINE_LENGTH);

   logic [TIME_W-1:0] timeout_ff;
   logic [TIME_W-1:0] last_time_ff;
   logic [CNT_W-1:0]  fill_ff;
   logic [CNT_W-1:0]  fill_in;
   logic [CHAR_W-1:0] store_ff [LINE_LENGTH];
   logic              out_valid_ff;
   logic              out_valid_in;
   frame_type         frame_ff;
   frame_type         frame_in;

   logic [TIME_W-1:0] gap;
   logic [CNT_W-1:0]  fill_eff;
   logic [CHAR_W-1:0] char_up;
   logic              store_en;
   logic              emit;
   frame_kind_type    kind;
   logic [NUM_CHARS-1:0][CHAR_W-1:0] line_chars;

   assign item_take = item_valid && (!out_valid_ff || out_ready);

   assign gap      = item.time_ms - last_time_ff;
   assign fill_eff = (gap > timeout_ff) ? '0 : fill_ff;
   assign char_up  = (item.rx_byte >= CH_LOWER_A && item.rx_byte <= CH_LOWER_Z) ?
                     (item.rx_byte - CASE_OFFSET) : item.rx_byte;

   always_comb begin
      fill_in  = fill_ff;
      store_en = 1'b0;
      emit     = 1'b0;
      kind     = KIND_LINE;
      if (item_take) begin
         priority if (item.rx_byte == CH_BACKSPACE) begin
            fill_in = (fill_eff != '0) ? fill_eff - 1'b1 : '0;
         end else if (item.rx_byte == CH_CR || item.rx_byte == CH_LF) begin
            fill_in = '0;
            if (fill_eff == FULL) begin
               emit = 1'b1;
            end else if (fill_eff != '0) begin
               emit = 1'b1;
               kind = KIND_ERROR;
            end
         end else if (fill_eff < FULL) begin
            store_en = 1'b1;
            fill_in  = fill_eff + 1'b1;
         end else begin
            fill_in = '0;
            emit    = 1'b1;
            kind    = KIND_ERROR;
         end
      end
   end

   for (genvar k = 0; k < NUM_CHARS; k++) begin : g_chars
      if (k < LINE_LENGTH) begin : g_held
         assign line_chars[k] = store_ff[k];
      end else begin : g_pad
         assign line_chars[k] = '0;
      end
   end

   always_comb begin
      frame_in.kind       = kind;
      frame_in.frame_time = item.time_ms;
      if (kind == KIND_ERROR) begin
         frame_in.chars = {CH_TWO, CH_ZERO, CH_ZERO, CH_ZERO, CH_E};
      end else begin
         frame_in.chars = line_chars;
      end
   end

   assign out_valid_in = item_take ? emit : (out_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         last_time_ff <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            timeout_ff <= csr_wdata;
         end
         if (item_take) begin
            last_time_ff <= item.time_ms;
         end
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   for (genvar k = 0; k < LINE_LENGTH; k++) begin : g_store
      always_ff @(posedge clock) begin
         if (store_en && fill_eff == CNT_W'(k)) begin
            store_ff[k] <= char_up;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && emit) begin
         frame_ff <= frame_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_frame = frame_ff;

endmodule

`default_nettype wire

// File: hw/rtl/fixed_length_command_line_framer.sv
// channel  dir  beat fields (low bit up)                         handshake
// req      in   tdata: rx_byte[7:0], time_ms[39:8]               tvalid/tready
// rsp      out  tdata: char_0..char_4[39:0], frame_time[71:40]   tvalid/tready
//               tuser: frame_kind (0 line, 1 error E0002)
// csr      in   csr_wdata: idle_timeout_ms, written when csr_we  none
//
// One byte per cycle sustained unless rsp stalls; frames pass the input and output registers.
// The input register feeds one pass of compare/store logic into the output register.
// Synchronous active-high reset clears fill count and last timestamp, sets timeout to 5000.
// A stalled rsp holds the byte in the input register; req_tready drops only then and in reset.
`default_nettype none

module fixed_length_command_line_framer
   import clf_pkg::*;
#(
   parameter int LINE_LENGTH = 5
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [39:0]  req_tdata,   // rx_byte, time_ms
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [71:0]       rsp_tdata,   // char_0, char_1, char_2, char_3, char_4, frame_time
   output logic              rsp_tuser,   // frame_kind
   input  wire logic         csr_we,
   input  wire logic [31:0]  csr_wdata    // idle_timeout_ms
);

   rx_item_type req_item;
   rx_item_type held_item;
   logic        held_valid;
   logic        take;
   frame_type   frame;

   assign req_item = rx_item_type'(req_tdata);

   clf_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_item   (req_item),
      .in_ready  (req_tready),
      .take      (take),
      .out_valid (held_valid),
      .out_item  (held_item)
   );

   clf_framer #(
      .LINE_LENGTH (LINE_LENGTH)
   ) u_framer (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .item_valid (held_valid),
      .item       (held_item),
      .item_take  (take),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_frame  (frame)
   );

   assign rsp_tdata = {frame.frame_time, frame.chars};
   assign rsp_tuser = frame.kind;

endmodule

`default_nettype wire

// File: hw/rtl/clf_checker.sv
`default_nettype none

module clf_checker
   import clf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [71:0] rsp_tdata,
   input  wire logic        rsp_tuser
);

   logic req_beat;
   assign req_beat = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   a_error_text: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[39:0] == {CH_TWO, CH_ZERO, CH_ZERO, CH_ZERO, CH_E})
      else $error("error frame text is not E0002");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_beat, 2))
      else $error("rsp beat without a req beat two cycles earlier");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp active right after reset");

endmodule

bind fixed_length_command_line_framer clf_checker u_clf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// File: dv/fixed_length_command_line_framer_tb.sv
`default_nettype none

module fixed_length_command_line_framer_tb
   import clf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD = 300;

   typedef enum {
      CHK_MODEL,
      CHK_NONE,
      CHK_FRAME
   } row_check_type;

   typedef struct {
      logic [CHAR_W-1:0] rx;
      logic [TIME_W-1:0] stamp;
      row_check_type     chk;
      frame_type         fr;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [39:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [71:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we;
   logic [31:0] csr_wdata;

   // line predictor state
   logic [CHAR_W-1:0] line_chars [NUM_CHARS];
   int                line_fill;
   logic [TIME_W-1:0] line_last_stamp;
   logic [TIME_W-1:0] line_timeout;

   frame_type pending_frames[$];
   stim_row_type directed_rows[27];

   logic [TIME_W-1:0] stamp_now;
   int  beats_sent;
   int  frames_seen;
   int  error_frames;
   int  mismatches;
   bit  req_idle_on;
   bit  rsp_idle_on;
   bit  hold_request;
   logic [31:0] mid_timeout;

   fixed_length_command_line_framer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit frame_for_byte(input logic [CHAR_W-1:0] rx,
                                         input logic [TIME_W-1:0] stamp,
                                         output frame_type fr);
      logic [TIME_W-1:0] gap;
      logic [CHAR_W-1:0] ch;
      bit hit;
      bit err;
      hit = 1'b0;
      err = 1'b0;
      fr = '0;
      gap = stamp - line_last_stamp;
      if (gap > line_timeout) line_fill = 0;
      line_last_stamp = stamp;
      if (rx == CH_BACKSPACE) begin
         if (line_fill > 0) line_fill--;
      end else if (rx == CH_CR || rx == CH_LF) begin
         if (line_fill == NUM_CHARS) begin
            hit = 1'b1;
            fr.kind = KIND_LINE;
            for (int k = 0; k < NUM_CHARS; k++) fr.chars[k] = line_chars[k];
         end else if (line_fill != 0) begin
            err = 1'b1;
         end
         line_fill = 0;
      end else if (line_fill < NUM_CHARS) begin
         ch = rx;
         if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ch = ch - CASE_OFFSET;
         line_chars[line_fill] = ch;
         line_fill++;
      end else begin
         err = 1'b1;
         line_fill = 0;
      end
      if (err) begin
         hit = 1'b1;
         fr.kind = KIND_ERROR;
         fr.chars = {CH_TWO, CH_ZERO, CH_ZERO, CH_ZERO, CH_E};
      end
      fr.frame_time = stamp;
      return hit;
   endfunction

   function automatic logic [TIME_W-1:0] pick_gap();
      case ($urandom_range(0, 63))
         0: return $urandom;
         1: return line_timeout;
         2: return line_timeout + 1;
         default: return (line_timeout < 40) ? $urandom_range(0, line_timeout)
                                             : $urandom_range(0, 40);
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] text_char();
      logic [CHAR_W-1:0] c;
      c = CHAR_W'($urandom_range(0, 255));
      if (c == CH_BACKSPACE || c == CH_CR || c == CH_LF) c = 8'h71;
      return c;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("frame %0d %s: expected %h got %h", frames_seen, name, want, got);
      end
   endfunction

   task automatic send_beat(input logic [CHAR_W-1:0] rx, input logic [TIME_W-1:0] stamp);
      int idle;
      idle = 0;
      if (req_idle_on && $urandom_range(0, 7) == 0) idle = $urandom_range(1, 12);
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {stamp, rx};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   task automatic send_char(input logic [CHAR_W-1:0] rx, input bit jump);
      frame_type fr;
      if (jump) stamp_now = stamp_now + line_timeout + 1 + $urandom_range(0, 50);
      else stamp_now = stamp_now + pick_gap();
      if (frame_for_byte(rx, stamp_now, fr)) pending_frames.push_back(fr);
      send_beat(rx, stamp_now);
   endtask

   task automatic random_lines(input int goal);
      int len;
      goal = beats_sent + goal;
      while (beats_sent < goal) begin
         case ($urandom_range(0, 9))
            6: begin
               len = $urandom_range(1, NUM_CHARS - 1);
               repeat (len) send_char(text_char(), 1'b0);
               send_char($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
            end
            7: begin
               len = $urandom_range(NUM_CHARS + 1, NUM_CHARS + 4);
               repeat (len) send_char(text_char(), 1'b0);
               if ($urandom_range(0, 1)) send_char(CH_CR, 1'b0);
            end
            8: begin
               repeat ($urandom_range(1, 4)) send_char(text_char(), 1'b0);
               send_char(text_char(), 1'b1);
            end
            9: begin
               repeat ($urandom_range(1, 6))
                  send_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
            end
            default: begin
               len = $urandom_range(0, NUM_CHARS - 1);
               for (int k = 0; k < NUM_CHARS; k++) begin
                  send_char(text_char(), 1'b0);
                  if (k == len && $urandom_range(0, 3) == 0) begin
                     send_char(CH_BACKSPACE, 1'b0);
                     send_char(text_char(), 1'b0);
                  end
               end
               send_char($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
            end
         endcase
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      line_timeout = value;
   endtask

   // result monitor
   always @(posedge clock) begin
      frame_type want;
      frame_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.chars      = rsp_tdata[39:0];
         got.frame_time = rsp_tdata[71:40];
         got.kind       = frame_kind_type'(rsp_tuser);
         if (pending_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected frame kind %0d chars %h time %h",
                        got.kind, got.chars, got.frame_time);
         end else begin
            want = pending_frames.pop_front();
            check_field("frame_kind", 32'(want.kind), 32'(got.kind));
            for (int k = 0; k < NUM_CHARS; k++)
               check_field($sformatf("char_%0d", k), 32'(want.chars[k]),
                           32'(got.chars[k]));
            check_field("frame_time", want.frame_time, got.frame_time);
         end
         frames_seen++;
         if (got.kind == KIND_ERROR) error_frames++;
      end
   end

   // receiver
   initial begin
      int hold;
      bit long_done;
      hold = 0;
      long_done = 1'b0;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (hold_request && !long_done) begin
            hold = LONG_HOLD;
            long_done = 1'b1;
         end else if (hold == 0 && rsp_idle_on && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 12);
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any beat
   initial begin
      int quiet;
      quiet = 0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d frames pending",
                     quiet, pending_frames.size());
            $display("fixed_length_command_line_framer_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      frame_type fr;
      bit hit;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      req_idle_on  = 1'b1;
      rsp_idle_on  = 1'b1;
      hold_request = 1'b0;
      beats_sent   = 0;
      frames_seen  = 0;
      error_frames = 0;
      mismatches   = 0;
      line_fill    = 0;
      line_last_stamp = '0;
      line_timeout = TIMEOUT_RESET;
      foreach (line_chars[k]) line_chars[k] = '0;

      directed_rows = '{
         '{"a",          32'd10,    CHK_NONE,  '0},
         '{"b",          32'd20,    CHK_MODEL, '0},
         '{CH_BACKSPACE, 32'd30,    CHK_NONE,  '0},
         '{"b",          32'd40,    CHK_MODEL, '0},
         '{"c",          32'd50,    CHK_MODEL, '0},
         '{"d",          32'd60,    CHK_MODEL, '0},
         '{"e",          32'd70,    CHK_MODEL, '0},
         '{CH_CR,        32'd80,    CHK_FRAME,
           '{KIND_LINE, 32'd80, {"E", "D", "C", "B", "A"}}},
         '{CH_LF,        32'd90,    CHK_NONE,  '0},
         '{CH_BACKSPACE, 32'd100,   CHK_NONE,  '0},
         '{"z",          32'd110,   CHK_MODEL, '0},
         '{CH_CR,        32'd120,   CHK_FRAME,
           '{KIND_ERROR, 32'd120, {CH_TWO, CH_ZERO, CH_ZERO, CH_ZERO, CH_E}}},
         '{8'h00,        32'd130,   CHK_MODEL, '0},
         '{8'hff,        32'd140,   CHK_MODEL, '0},
         '{8'h60,        32'd150,   CHK_MODEL, '0},
         '{8'h7b,        32'd160,   CHK_MODEL, '0},
         '{8'h7a,        32'd170,   CHK_MODEL, '0},
         // sixth char overflows the line
         '{"A",          32'd180,   CHK_FRAME,
           '{KIND_ERROR, 32'd180, {CH_TWO, CH_ZERO, CH_ZERO, CH_ZERO, CH_E}}},
         '{"1",          32'd190,   CHK_MODEL, '0},
         // gap 5001 drops the partial line, gap 5000 keeps it
         '{"2",          32'd5191,  CHK_MODEL, '0},
         '{"3",          32'd10191, CHK_MODEL, '0},
         '{"4",          32'hffff_fff0, CHK_MODEL, '0},
         // timestamp wraps
         '{"5",          32'h8,     CHK_MODEL, '0},
         '{"6",          32'h10,    CHK_MODEL, '0},
         '{"7",          32'h18,    CHK_MODEL, '0},
         '{"8",          32'h20,    CHK_MODEL, '0},
         '{CH_LF,        32'h28,    CHK_MODEL, '0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         hit = frame_for_byte(directed_rows[i].rx, directed_rows[i].stamp, fr);
         case (directed_rows[i].chk)
            CHK_MODEL: if (hit) pending_frames.push_back(fr);
            CHK_FRAME: pending_frames.push_back(directed_rows[i].fr);
            default: ;
         endcase
         send_beat(directed_rows[i].rx, directed_rows[i].stamp);
      end
      stamp_now = 32'h28;
      random_lines(250);
      drain();

      write_timeout(32'd0);
      random_lines(200);
      drain();

      write_timeout(32'hffff_ffff);
      hold_request <= 1'b1;
      random_lines(200);
      drain();

      mid_timeout = $urandom_range(1, 200);
      write_timeout(mid_timeout);
      random_lines(250);
      drain();

      write_timeout(TIMEOUT_RESET);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      random_lines(300);
      drain();

      $display("covered %0d beats, %0d frames of which %0d length errors", beats_sent,
               frames_seen, error_frames);
      $display("timeouts 5000, 0, max, %0d and 5000 again, one long receiver stall",
               mid_timeout);
      if (mismatches == 0) begin
         $display("fixed_length_command_line_framer_tb OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("fixed_length_command_line_framer_tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
